// ===== rtl/scdec_pkg.sv =====
// shared constants, types and key tables for the set-1 scancode decoder
`timescale 1ns / 1ps
`default_nettype none

package scdec_pkg;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam int unsigned BREAK_BIT  = 7;
  localparam logic [6:0] KEY_ALT     = 7'h38;
  localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT  = 7'h36;
  localparam logic [6:0] KEY_CTRL    = 7'h1D;
  localparam logic [6:0] KEY_UP      = 7'h48;
  localparam logic [6:0] KEY_DOWN    = 7'h50;
  localparam logic [6:0] KEY_RIGHT   = 7'h4D;
  localparam logic [6:0] KEY_LEFT    = 7'h4B;
  localparam logic [6:0] KEY_ISO102  = 7'd86;

  localparam logic [7:0] CHAR_ESC     = 8'h1B;
  localparam logic [7:0] CHAR_BRACKET = 8'h5B;
  localparam logic [7:0] CHAR_A_UP    = 8'h41;
  localparam logic [7:0] CHAR_B_DOWN  = 8'h42;
  localparam logic [7:0] CHAR_C_RIGHT = 8'h43;
  localparam logic [7:0] CHAR_D_LEFT  = 8'h44;
  localparam logic [7:0] CHAR_LT      = 8'h3C;
  localparam logic [7:0] CHAR_GT      = 8'h3E;
  localparam logic [7:0] CHAR_BAR     = 8'h7C;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CTRL_OFFSET  = 8'h60;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_CHAR,
    EMIT_ESCAPE
  } emit_t;

  function automatic logic [7:0] base_char(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'd1:  ch = 8'h1B;
      7'd2:  ch = 8'h31;
      7'd3:  ch = 8'h32;
      7'd4:  ch = 8'h33;
      7'd5:  ch = 8'h34;
      7'd6:  ch = 8'h35;
      7'd7:  ch = 8'h36;
      7'd8:  ch = 8'h37;
      7'd9:  ch = 8'h38;
      7'd10: ch = 8'h39;
      7'd11: ch = 8'h30;
      7'd12: ch = 8'h2D;
      7'd13: ch = 8'h2B;
      7'd14: ch = 8'h08;
      7'd15: ch = 8'h09;
      7'd16: ch = 8'h71;
      7'd17: ch = 8'h77;
      7'd18: ch = 8'h65;
      7'd19: ch = 8'h72;
      7'd20: ch = 8'h74;
      7'd21: ch = 8'h79;
      7'd22: ch = 8'h75;
      7'd23: ch = 8'h69;
      7'd24: ch = 8'h6F;
      7'd25: ch = 8'h70;
      7'd26: ch = 8'h86;
      7'd27: ch = 8'h5E;
      7'd28: ch = 8'h0A;
      7'd30: ch = 8'h61;
      7'd31: ch = 8'h73;
      7'd32: ch = 8'h64;
      7'd33: ch = 8'h66;
      7'd34: ch = 8'h67;
      7'd35: ch = 8'h68;
      7'd36: ch = 8'h6A;
      7'd37: ch = 8'h6B;
      7'd38: ch = 8'h6C;
      7'd39: ch = 8'h91;
      7'd40: ch = 8'h9B;
      7'd41: ch = 8'h60;
      7'd43: ch = 8'h5C;
      7'd44: ch = 8'h7A;
      7'd45: ch = 8'h78;
      7'd46: ch = 8'h63;
      7'd47: ch = 8'h76;
      7'd48: ch = 8'h62;
      7'd49: ch = 8'h6E;
      7'd50: ch = 8'h6D;
      7'd51: ch = 8'h2C;
      7'd52: ch = 8'h2E;
      7'd53: ch = 8'h2D;
      7'd55: ch = 8'h2A;
      7'd57: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] shift_char(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'd1:  ch = 8'h1B;
      7'd2:  ch = 8'h21;
      7'd3:  ch = 8'h22;
      7'd4:  ch = 8'h23;
      7'd5:  ch = 8'hA4;
      7'd6:  ch = 8'h25;
      7'd7:  ch = 8'h26;
      7'd8:  ch = 8'h2F;
      7'd9:  ch = 8'h28;
      7'd10: ch = 8'h29;
      7'd11: ch = 8'h3D;
      7'd12: ch = 8'h5F;
      7'd13: ch = 8'h3F;
      7'd14: ch = 8'h08;
      7'd15: ch = 8'h09;
      7'd16: ch = 8'h51;
      7'd17: ch = 8'h57;
      7'd18: ch = 8'h45;
      7'd19: ch = 8'h52;
      7'd20: ch = 8'h54;
      7'd21: ch = 8'h59;
      7'd22: ch = 8'h55;
      7'd23: ch = 8'h49;
      7'd24: ch = 8'h4F;
      7'd25: ch = 8'h50;
      7'd26: ch = 8'h8F;
      7'd27: ch = 8'hF9;
      7'd28: ch = 8'h0A;
      7'd30: ch = 8'h41;
      7'd31: ch = 8'h53;
      7'd32: ch = 8'h44;
      7'd33: ch = 8'h46;
      7'd34: ch = 8'h47;
      7'd35: ch = 8'h48;
      7'd36: ch = 8'h4A;
      7'd37: ch = 8'h4B;
      7'd38: ch = 8'h4C;
      7'd39: ch = 8'h92;
      7'd40: ch = 8'h9D;
      7'd41: ch = 8'h7E;
      7'd43: ch = 8'h7C;
      7'd44: ch = 8'h5A;
      7'd45: ch = 8'h58;
      7'd46: ch = 8'h43;
      7'd47: ch = 8'h56;
      7'd48: ch = 8'h42;
      7'd49: ch = 8'h4E;
      7'd50: ch = 8'h4D;
      7'd51: ch = 8'h3B;
      7'd52: ch = 8'h3A;
      7'd53: ch = 8'h5F;
      7'd55: ch = 8'h2A;
      7'd57: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] altgr_char(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'd3:  ch = 8'h40;
      7'd4:  ch = 8'h9C;
      7'd5:  ch = 8'h24;
      7'd8:  ch = 8'h7B;
      7'd9:  ch = 8'h5B;
      7'd10: ch = 8'h5D;
      7'd11: ch = 8'h7D;
      7'd12: ch = 8'h5C;
      7'd56: ch = 8'h2A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scancode_set1_to_char_decoder.sv =====
// top level: set-1 scancode to danish character decoder
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake               | payload
// --------+-------------------------+------------------------------
// scan    | scan_valid / scan_ready | scan_byte[7:0]
// char    | char_valid / char_ready | char_out[7:0], last_of_run
//
// a scan beat lands in an input register, is decoded in one pass and loaded
// into the output register; one byte per cycle is taken while the output is free
// a character key gives one char beat, an extended arrow gives three beats
// (esc, '[', letter) in that order from the output register
// reset clears the prefix and modifier flags and empties both registers
// a stalled char beat holds; the input register still takes one scan beat

module scancode_set1_to_char_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] scan_byte,
  input  wire logic       scan_valid,
  output logic            scan_ready,
  output logic [7:0]      char_out,
  output logic            last_of_run,
  output logic            char_valid,
  input  wire logic       char_ready
);
  import scdec_pkg::*;

  // input register
  logic       in_full;
  logic [7:0] in_byte;

  // key state
  logic extended_pending, extended_pending_next;
  logic shift_held, shift_held_next;
  logic control_held, control_held_next;
  logic altgr_held, altgr_held_next;

  // output register and the rest of an escape run
  logic [1:0] remaining;
  logic [7:0] tail;

  // decode results
  emit_t      emit;
  logic [7:0] dec_char;
  logic [7:0] dec_tail;
  logic [7:0] key_char;
  logic [7:0] alt_char;
  logic [6:0] code;

  logic out_fire;
  logic in_take;
  logic scan_fire;

  assign out_fire   = char_valid && char_ready;
  // decoded byte moves on when the output is empty or its final beat leaves
  assign in_take    = in_full && (!char_valid || (out_fire && remaining == 2'd0));
  assign scan_ready = !in_full || in_take;
  assign scan_fire  = scan_valid && scan_ready;

  assign code     = in_byte[6:0];
  assign alt_char = altgr_char(code);

  always_comb begin
    extended_pending_next = extended_pending;
    shift_held_next       = shift_held;
    control_held_next     = control_held;
    altgr_held_next       = altgr_held;
    emit                  = EMIT_NONE;
    dec_char              = CHAR_ESC;
    dec_tail              = CHAR_A_UP;
    key_char              = 8'h00;

    // table lookup with altgr only where its entry exists
    if (code == KEY_ISO102) begin
      key_char = altgr_held ? CHAR_BAR : (shift_held ? CHAR_GT : CHAR_LT);
    end else if (altgr_held && alt_char != 8'h00) begin
      key_char = alt_char;
    end else if (shift_held) begin
      key_char = shift_char(code);
    end else begin
      key_char = base_char(code);
    end

    if (in_byte == PREFIX_BYTE) begin
      extended_pending_next = 1'b1;
    end else begin
      extended_pending_next = 1'b0;
      if (in_byte[BREAK_BIT]) begin
        // break: only modifiers are released
        if (extended_pending && code == KEY_ALT) begin
          altgr_held_next = 1'b0;
        end else if (code inside {KEY_LSHIFT, KEY_RSHIFT}) begin
          shift_held_next = 1'b0;
        end else if (code == KEY_CTRL) begin
          control_held_next = 1'b0;
        end
      end else if (extended_pending && code == KEY_ALT) begin
        altgr_held_next = 1'b1;
      end else if (code inside {KEY_LSHIFT, KEY_RSHIFT}) begin
        shift_held_next = 1'b1;
      end else if (code == KEY_CTRL) begin
        control_held_next = 1'b1;
      end else if (code == KEY_ALT) begin
        // left alt never changes the output
      end else if (extended_pending) begin
        emit = EMIT_ESCAPE;
        case (code)
          KEY_UP:    dec_tail = CHAR_A_UP;
          KEY_DOWN:  dec_tail = CHAR_B_DOWN;
          KEY_RIGHT: dec_tail = CHAR_C_RIGHT;
          KEY_LEFT:  dec_tail = CHAR_D_LEFT;
          default:   emit     = EMIT_NONE;
        endcase
      end else if (key_char != 8'h00) begin
        emit = EMIT_CHAR;
        if (control_held && key_char inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
          dec_char = key_char - CTRL_OFFSET;
        end else begin
          dec_char = key_char;
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (scan_fire) begin
      in_full <= 1'b1;
    end else if (in_take) begin
      in_full <= 1'b0;
    end
    if (scan_fire) begin
      in_byte <= scan_byte;
    end
  end

  // key state follows each decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      extended_pending <= 1'b0;
      shift_held       <= 1'b0;
      control_held     <= 1'b0;
      altgr_held       <= 1'b0;
    end else if (in_take) begin
      extended_pending <= extended_pending_next;
      shift_held       <= shift_held_next;
      control_held     <= control_held_next;
      altgr_held       <= altgr_held_next;
    end
  end

  // output register; an escape run steps esc, bracket, letter
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      remaining  <= 2'd0;
    end else if (out_fire && remaining != 2'd0) begin
      remaining <= remaining - 2'd1;
      if (remaining == 2'd2) begin
        char_out    <= CHAR_BRACKET;
        last_of_run <= 1'b0;
      end else begin
        char_out    <= tail;
        last_of_run <= 1'b1;
      end
    end else if (in_take) begin
      char_valid <= (emit != EMIT_NONE);
      char_out   <= dec_char;
      tail       <= dec_tail;
      if (emit == EMIT_ESCAPE) begin
        remaining   <= 2'd2;
        last_of_run <= 1'b0;
      end else begin
        remaining   <= 2'd0;
        last_of_run <= 1'b1;
      end
    end else if (out_fire) begin
      char_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
